// ----- hdl/ssd_pkg.sv -----
// Shared types, constants and helpers for the sorted-set symmetric difference block.
// Used by ssd_store, sorted_set_symmetric_difference, ssd_checker and the testbench; depends on nothing else.
`default_nettype none

package ssd_pkg;

  localparam int unsigned ElemW      = 32;
  localparam int unsigned MaxResults = 32;
  localparam int unsigned ResCntW    = 6;

  typedef struct packed {
    logic signed [ElemW-1:0] element_value;
    logic                    req_type;
    logic                    final_item;
  } req_t;

  typedef struct packed {
    logic signed [ElemW-1:0] diff_value;
    logic                    last_result;
    logic                    result_empty;
    logic                    overflow_seen;
  } res_t;

  // Control from the top level to one set store.
  typedef struct packed {
    logic wr;
    logic sort_start;
    logic clear;
    logic rd_en;
  } store_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY,
    ST_CMP,
    ST_PLACE
  } sort_state_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SORT_GO,
    T_SORT,
    T_FETCH,
    T_MERGE,
    T_FLUSH
  } top_state_e;

  // Set values are 32-bit two's complement words.
  typedef enum logic {
    SET_A = 1'b0,
    SET_B = 1'b1
  } set_sel_e;

  function automatic logic less_signed(input logic [ElemW-1:0] x, input logic [ElemW-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ssd_store.sv -----
// One set store: a synchronous memory with its fill count and an in-place insertion sort.
// Depends on ssd_pkg for the control struct, the sort state type and the signed compare.
`default_nettype none

module ssd_store #(
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ssd_pkg::store_ctl_t         ctl_i,
  input  wire logic [ssd_pkg::ElemW-1:0]   wr_data_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [ssd_pkg::ElemW-1:0]   rd_data_o,
  output logic      [CW-1:0]               count_o,
  output logic                             busy_o
);

  logic [ssd_pkg::ElemW-1:0] mem [Depth];
  logic [ssd_pkg::ElemW-1:0] rd_data_q;

  ssd_pkg::sort_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] p_q, p_d;
  logic [CW-1:0] q_q, q_d;
  logic [ssd_pkg::ElemW-1:0] key_q, key_d;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [ssd_pkg::ElemW-1:0] wdata;
  logic                      re;
  logic [AW-1:0]             raddr;

  logic [CW-1:0] q_m1, q_m2, p_p1;
  logic          shift;
  logic          pass_done;

  assign q_m1      = q_q - CW'(1);
  assign q_m2      = q_q - CW'(2);
  assign p_p1      = p_q + CW'(1);
  assign shift     = ssd_pkg::less_signed(key_q, rd_data_q);
  assign pass_done = (p_p1 == count_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::ST_IDLE;
      count_q <= '0;
      p_q     <= '0;
      q_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      p_q     <= p_d;
      q_q     <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ssd_pkg::ST_IDLE: begin
        if (ctl_i.sort_start && (count_q > CW'(1))) begin
          state_d = ssd_pkg::ST_KEY_RD;
        end
      end
      ssd_pkg::ST_KEY_RD: state_d = ssd_pkg::ST_KEY;
      ssd_pkg::ST_KEY:    state_d = ssd_pkg::ST_CMP;
      ssd_pkg::ST_CMP: begin
        if (shift) begin
          state_d = (q_q == CW'(1)) ? ssd_pkg::ST_PLACE : ssd_pkg::ST_CMP;
        end else begin
          state_d = pass_done ? ssd_pkg::ST_IDLE : ssd_pkg::ST_KEY_RD;
        end
      end
      ssd_pkg::ST_PLACE: begin
        state_d = pass_done ? ssd_pkg::ST_IDLE : ssd_pkg::ST_KEY_RD;
      end
      default: state_d = ssd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = count_q[AW-1:0];
    wdata   = key_q;
    re      = 1'b0;
    raddr   = rd_addr_i;
    count_d = count_q;
    p_d     = p_q;
    q_d     = q_q;
    key_d   = key_q;
    case (state_q)
      ssd_pkg::ST_IDLE: begin
        if (ctl_i.wr) begin
          we      = 1'b1;
          wdata   = wr_data_i;
          count_d = count_q + CW'(1);
        end
        if (ctl_i.clear) begin
          count_d = '0;
        end
        if (ctl_i.sort_start) begin
          p_d = CW'(1);
        end
        re = ctl_i.rd_en;
      end
      ssd_pkg::ST_KEY_RD: begin
        re    = 1'b1;
        raddr = p_q[AW-1:0];
        q_d   = p_q;
      end
      ssd_pkg::ST_KEY: begin
        key_d = rd_data_q;
        re    = 1'b1;
        raddr = q_m1[AW-1:0];
      end
      ssd_pkg::ST_CMP: begin
        we    = 1'b1;
        waddr = q_q[AW-1:0];
        if (shift) begin
          // Move the larger neighbor up one slot and look further down.
          wdata = rd_data_q;
          q_d   = q_m1;
          if (q_q != CW'(1)) begin
            re    = 1'b1;
            raddr = q_m2[AW-1:0];
          end
        end else begin
          wdata = key_q;
          p_d   = p_p1;
        end
      end
      ssd_pkg::ST_PLACE: begin
        we    = 1'b1;
        waddr = q_q[AW-1:0];
        wdata = key_q;
        p_d   = p_p1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;
  assign busy_o    = (state_q != ssd_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ----- hdl/sorted_set_symmetric_difference.sv -----
// Top level: loads words into two set stores, sorts them in place, then merges them into
// the symmetric difference. Depends on ssd_pkg and ssd_store.
// Order of work: a load word is taken whenever busy is low. A final word then starts the
// sort, an insertion sort in both stores at once; the merge follows, each step consuming
// one element, or one from each set on a match, and a flush step strobes the last result.
// Results are strobed for one cycle each; the receiver cannot stall. busy is high from the
// cycle after the final word until the last result is strobed, when the next load may begin.
// Reset clears counts and control, not the memories.
`default_nettype none

module sorted_set_symmetric_difference #(
  parameter int unsigned SetDepth = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ssd_pkg::req_t req_i,
  output logic               result_strobe_o,
  output ssd_pkg::res_t      res_o
);

  localparam int unsigned AW = (SetDepth > 1) ? $clog2(SetDepth) : 1;
  localparam int unsigned CW = $clog2(SetDepth + 1);

  ssd_pkg::top_state_e state_q, state_d;

  logic                      ovf_q, ovf_d;
  logic [CW-1:0]             i_q, i_d, j_q, j_d;
  logic [ssd_pkg::ElemW-1:0] last_a_q, last_a_d, last_b_q, last_b_d;
  logic                      have_la_q, have_la_d, have_lb_q, have_lb_d;
  logic [ssd_pkg::ElemW-1:0] pend_q, pend_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [ssd_pkg::ResCntW-1:0] found_q, found_d;
  logic                      strobe_q, strobe_d;
  ssd_pkg::res_t             res_q, res_d;

  ssd_pkg::store_ctl_t       ctl_a, ctl_b;
  logic [ssd_pkg::ElemW-1:0] data_a, data_b;
  logic [CW-1:0]             count_a, count_b;
  logic                      busy_a, busy_b;

  logic accept;
  logic av, bv;
  logic take;
  logic [ssd_pkg::ElemW-1:0] take_val;

  assign busy   = (state_q != ssd_pkg::T_IDLE);
  assign accept = start && !busy;
  assign av     = (i_q < count_a);
  assign bv     = (j_q < count_b);

  always_comb begin
    ctl_a            = '0;
    ctl_b            = '0;
    ctl_a.wr         = accept && (req_i.req_type == ssd_pkg::SET_A) &&
                       (count_a < CW'(SetDepth));
    ctl_b.wr         = accept && (req_i.req_type == ssd_pkg::SET_B) &&
                       (count_b < CW'(SetDepth));
    ctl_a.sort_start = (state_q == ssd_pkg::T_SORT_GO);
    ctl_b.sort_start = (state_q == ssd_pkg::T_SORT_GO);
    ctl_a.clear      = (state_q == ssd_pkg::T_FLUSH);
    ctl_b.clear      = (state_q == ssd_pkg::T_FLUSH);
    ctl_a.rd_en      = (state_q == ssd_pkg::T_FETCH) && av;
    ctl_b.rd_en      = (state_q == ssd_pkg::T_FETCH) && bv;
  end

  ssd_store #(.Depth(SetDepth)) u_store_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_a),
    .wr_data_i (req_i.element_value),
    .rd_addr_i (i_q[AW-1:0]),
    .rd_data_o (data_a),
    .count_o   (count_a),
    .busy_o    (busy_a)
  );

  ssd_store #(.Depth(SetDepth)) u_store_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_b),
    .wr_data_i (req_i.element_value),
    .rd_addr_i (j_q[AW-1:0]),
    .rd_data_o (data_b),
    .count_o   (count_b),
    .busy_o    (busy_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ssd_pkg::T_IDLE;
      ovf_q        <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      have_la_q    <= 1'b0;
      have_lb_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      found_q      <= '0;
      strobe_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      ovf_q        <= ovf_d;
      i_q          <= i_d;
      j_q          <= j_d;
      have_la_q    <= have_la_d;
      have_lb_q    <= have_lb_d;
      pend_valid_q <= pend_valid_d;
      found_q      <= found_d;
      strobe_q     <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_a_q <= last_a_d;
    last_b_q <= last_b_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssd_pkg::T_IDLE: begin
        if (accept && req_i.final_item) begin
          state_d = ssd_pkg::T_SORT_GO;
        end
      end
      ssd_pkg::T_SORT_GO: state_d = ssd_pkg::T_SORT;
      ssd_pkg::T_SORT: begin
        if (!busy_a && !busy_b) begin
          state_d = ssd_pkg::T_FETCH;
        end
      end
      ssd_pkg::T_FETCH: begin
        if (!(av || bv) || (found_q == ssd_pkg::ResCntW'(ssd_pkg::MaxResults))) begin
          state_d = ssd_pkg::T_FLUSH;
        end else begin
          state_d = ssd_pkg::T_MERGE;
        end
      end
      ssd_pkg::T_MERGE: state_d = ssd_pkg::T_FETCH;
      ssd_pkg::T_FLUSH: state_d = ssd_pkg::T_IDLE;
      default:          state_d = ssd_pkg::T_IDLE;
    endcase
  end

  // Merge step: duplicates within a set are skipped against the last value consumed
  // from that set, so the sorted stores need no separate dedup pass.
  // The merge registers only change in the merge state and are cleared while sorting.
  always_comb begin
    take     = 1'b0;
    take_val = data_a;
    i_d      = i_q;
    j_d      = j_q;
    last_a_d = last_a_q;
    last_b_d = last_b_q;
    have_la_d = have_la_q;
    have_lb_d = have_lb_q;
    case (state_q)
      ssd_pkg::T_SORT: begin
        i_d       = '0;
        j_d       = '0;
        have_la_d = 1'b0;
        have_lb_d = 1'b0;
      end
      ssd_pkg::T_MERGE: begin
        if (av && have_la_q && (data_a == last_a_q)) begin
          i_d = i_q + CW'(1);
        end else if (bv && have_lb_q && (data_b == last_b_q)) begin
          j_d = j_q + CW'(1);
        end else if (!bv || (av && ssd_pkg::less_signed(data_a, data_b))) begin
          take      = 1'b1;
          take_val  = data_a;
          i_d       = i_q + CW'(1);
          last_a_d  = data_a;
          have_la_d = 1'b1;
        end else if (!av || ssd_pkg::less_signed(data_b, data_a)) begin
          take      = 1'b1;
          take_val  = data_b;
          j_d       = j_q + CW'(1);
          last_b_d  = data_b;
          have_lb_d = 1'b1;
        end else begin
          i_d       = i_q + CW'(1);
          j_d       = j_q + CW'(1);
          last_a_d  = data_a;
          last_b_d  = data_b;
          have_la_d = 1'b1;
          have_lb_d = 1'b1;
        end
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // Datapath and result register, per state.
  always_comb begin
    ovf_d        = ovf_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    found_d      = found_q;
    strobe_d     = 1'b0;
    res_d        = res_q;
    case (state_q)
      ssd_pkg::T_IDLE: begin
        if (accept && !ctl_a.wr && !ctl_b.wr) begin
          ovf_d = 1'b1;
        end
      end
      ssd_pkg::T_SORT: begin
        pend_valid_d = 1'b0;
        found_d      = '0;
      end
      ssd_pkg::T_MERGE: begin
        // A result is held back one step so the final one can carry last_result.
        if (take) begin
          if (pend_valid_q) begin
            strobe_d            = 1'b1;
            res_d.diff_value    = pend_q;
            res_d.last_result   = 1'b0;
            res_d.result_empty  = 1'b0;
            res_d.overflow_seen = ovf_q;
          end
          pend_d       = take_val;
          pend_valid_d = 1'b1;
          found_d      = found_q + ssd_pkg::ResCntW'(1);
        end
      end
      ssd_pkg::T_FLUSH: begin
        strobe_d            = 1'b1;
        res_d.diff_value    = pend_valid_q ? pend_q : '0;
        res_d.last_result   = 1'b1;
        res_d.result_empty  = !pend_valid_q;
        res_d.overflow_seen = ovf_q;
        ovf_d               = 1'b0;
        pend_valid_d        = 1'b0;
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  assign result_strobe_o = strobe_q;
  assign res_o           = res_q;

endmodule

`default_nettype wire

// ----- verif/ssd_checker.sv -----
// Checker for the sorted-set symmetric difference block: tracks accepted words, predicts the
// difference on each final word and compares every strobed result in order.
// Depends on ssd_pkg for the word types and the result limit.
`default_nettype none

module ssd_checker #(
  parameter int unsigned SetDepth = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          busy_i,
  input  wire ssd_pkg::req_t req_i,
  input  wire logic          result_strobe_i,
  input  wire ssd_pkg::res_t res_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  typedef logic signed [ElemW-1:0] elem_t;

  elem_t       set_a [SetDepth];
  elem_t       set_b [SetDepth];
  int unsigned fill_a  = 0;
  int unsigned fill_b  = 0;
  bit          dropped = 1'b0;
  int          failures = 0;
  res_t        diff_expected [$];

  // Insertion sort followed by removal of repeated values.
  task automatic sort_unique(input elem_t src [SetDepth], input int n,
                             output elem_t dst [SetDepth], output int m);
    elem_t tmp [SetDepth];
    elem_t v;
    int    p;
    int    q;
    tmp = src;
    for (p = 1; p < n; p++) begin
      v = tmp[p];
      q = p;
      while (q > 0 && v < tmp[q-1]) begin
        tmp[q] = tmp[q-1];
        q--;
      end
      tmp[q] = v;
    end
    dst = tmp;
    m = 0;
    for (p = 0; p < n; p++) begin
      if (m == 0 || tmp[p] != dst[m-1]) begin
        dst[m] = tmp[p];
        m++;
      end
    end
  endtask

  task automatic predict_difference();
    elem_t uniq_a [SetDepth];
    elem_t uniq_b [SetDepth];
    elem_t picked [MaxResults];
    int    na;
    int    nb;
    int    i;
    int    j;
    int    k;
    int    idx;
    sort_unique(set_a, int'(fill_a), uniq_a, na);
    sort_unique(set_b, int'(fill_b), uniq_b, nb);
    i = 0;
    j = 0;
    k = 0;
    while ((i < na || j < nb) && k < int'(MaxResults)) begin
      if (j >= nb || (i < na && uniq_a[i] < uniq_b[j])) begin
        picked[k] = uniq_a[i];
        k++;
        i++;
      end else if (i >= na || uniq_b[j] < uniq_a[i]) begin
        picked[k] = uniq_b[j];
        k++;
        j++;
      end else begin
        i++;
        j++;
      end
    end
    if (k == 0) begin
      diff_expected.push_back(res_t'{diff_value: '0, last_result: 1'b1, result_empty: 1'b1,
                                     overflow_seen: dropped});
    end
    for (idx = 0; idx < k; idx++) begin
      diff_expected.push_back(res_t'{diff_value: picked[idx], last_result: idx == k - 1,
                                     result_empty: 1'b0, overflow_seen: dropped});
    end
    fill_a  = 0;
    fill_b  = 0;
    dropped = 1'b0;
  endtask

  task automatic take_word(input req_t w);
    // The word is stored, or dropped on a full set, before any computation starts.
    if (w.req_type == SET_B) begin
      if (fill_b < SetDepth) begin
        set_b[fill_b] = w.element_value;
        fill_b++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      if (fill_a < SetDepth) begin
        set_a[fill_a] = w.element_value;
        fill_a++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (w.final_item) begin
      predict_difference();
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (diff_expected.size() == 0) begin
      $display("%0t: unexpected result word, got %h", $time, got);
      failures++;
    end else begin
      want = diff_expected.pop_front();
      if (got.diff_value !== want.diff_value) begin
        $display("%0t: diff_value expected %0d, actual %0d", $time, want.diff_value,
                 got.diff_value);
        failures++;
      end
      if (got.last_result !== want.last_result) begin
        $display("%0t: last_result expected %0b, actual %0b", $time, want.last_result,
                 got.last_result);
        failures++;
      end
      if (got.result_empty !== want.result_empty) begin
        $display("%0t: result_empty expected %0b, actual %0b", $time, want.result_empty,
                 got.result_empty);
        failures++;
      end
      if (got.overflow_seen !== want.overflow_seen) begin
        $display("%0t: overflow_seen expected %0b, actual %0b", $time, want.overflow_seen,
                 got.overflow_seen);
        failures++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        take_word(req_i);
      end
      if (result_strobe_i) begin
        check_result(res_i);
      end
    end
    fail_count_o <= failures;
    pending_o    <= diff_expected.size();
  end

endmodule

`default_nettype wire

// ----- verif/tb_sorted_set_symmetric_difference.sv -----
// Testbench top for sorted_set_symmetric_difference: drives directed and random set loads
// through the start/busy handshake and reports the verdict from ssd_checker.
// Depends on ssd_pkg, ssd_checker and the block itself.
`default_nettype none

module tb_sorted_set_symmetric_difference;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int          WordTarget = 230;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic result_strobe_o;
  res_t res_o;
  int   fail_count;
  int   pending;
  int   words_sent = 0;

  always #5 clk_i = ~clk_i;

  sorted_set_symmetric_difference #(
    .SetDepth(Depth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_strobe_o(result_strobe_o),
    .res_o          (res_o)
  );

  ssd_checker #(
    .SetDepth(Depth)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req_i),
    .result_strobe_i(result_strobe_o),
    .res_i          (res_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  task automatic send_word(input logic [ElemW-1:0] value, input set_sel_e which,
                           input logic fin);
    int gap;
    // Words 90 to 149 go out back to back.
    if ((words_sent < 90 || words_sent >= 150) && $urandom_range(99) < 23) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      req_i <= req_t'({$urandom, 2'($urandom_range(3))});
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= req_t'{element_value: value, req_type: which, final_item: fin};
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  function automatic logic [ElemW-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      return ElemW'($signed($urandom_range(12)) - 6);
    end else if (r < 65) begin
      case ($urandom_range(5))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        4:       return 32'h8000_0001;
        default: return 32'h7FFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  // One load: the two sets filled in random interleaving, the last word marked final.
  task automatic run_load(input int n_a, input int n_b);
    int       left_a;
    int       left_b;
    int       total;
    int       k;
    set_sel_e which;
    left_a = n_a;
    left_b = n_b;
    total  = n_a + n_b;
    for (k = 0; k < total; k++) begin
      if (left_a == 0) begin
        which = SET_B;
      end else if (left_b == 0) begin
        which = SET_A;
      end else begin
        which = ($urandom_range(left_a + left_b - 1) < left_a) ? SET_A : SET_B;
      end
      if (which == SET_A) begin
        left_a--;
      end else begin
        left_b--;
      end
      send_word(pick_value(), which, k == total - 1);
    end
  endtask

  initial begin
    int n_a;
    int n_b;
    int guard;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Only one set loaded, at each end of the range.
    send_word(32'h8000_0000, SET_A, 1'b1);
    send_word(32'h7FFF_FFFF, SET_B, 1'b1);
    // Identical sets give the empty difference.
    send_word(32'd5, SET_A, 1'b0);
    send_word(32'd5, SET_B, 1'b1);
    send_word(32'hFFFF_FFFF, SET_B, 1'b0);
    send_word(32'hFFFF_FFFF, SET_A, 1'b1);
    // Repeated values inside one set and across both.
    send_word(32'd3, SET_A, 1'b0);
    send_word(32'd3, SET_A, 1'b0);
    send_word(32'hFFFF_FFFF, SET_A, 1'b0);
    send_word(32'hFFFF_FFFF, SET_B, 1'b0);
    send_word(32'd7, SET_B, 1'b1);
    // Ordering across the sign boundary.
    send_word(32'h7FFF_FFFF, SET_A, 1'b0);
    send_word(32'h8000_0000, SET_A, 1'b0);
    send_word(32'h0000_0000, SET_A, 1'b0);
    send_word(32'hFFFF_FFFF, SET_A, 1'b0);
    send_word(32'h0000_0000, SET_B, 1'b1);

    while (words_sent < WordTarget) begin
      if ($urandom_range(99) < 15) begin
        // One set runs past its depth so later words are dropped.
        if ($urandom_range(1)) begin
          n_a = $urandom_range(Depth + 4, Depth + 1);
          n_b = $urandom_range(6);
        end else begin
          n_a = $urandom_range(6);
          n_b = $urandom_range(Depth + 4, Depth + 1);
        end
      end else begin
        n_a = $urandom_range(7);
        n_b = $urandom_range(7);
        if (n_a + n_b == 0) begin
          n_a = 1;
        end
      end
      run_load(n_a, n_b);
    end
    start <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_set_symmetric_difference: match");
    end else begin
      $display("sorted_set_symmetric_difference: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("sorted_set_symmetric_difference: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
